@@ sv/i2ctrf_pkg.sv @@
// shared constants, codes and control types of the i2c target register file
package i2ctrf_pkg;

   // size of the register map and of the bus staging buffer
   localparam int REG_ENTRIES = 32;
   localparam int STAGE_DEPTH = REG_ENTRIES + 1;

   // item field widths
   localparam int KIND_W = 3;
   localparam int ADDR_W = 8;
   localparam int DATA_W = 8;
   localparam int LEN_W  = 7;

   // derived widths
   localparam int REG_AW = (REG_ENTRIES > 1) ? $clog2(REG_ENTRIES) : 1;
   localparam int STG_AW = $clog2(STAGE_DEPTH);
   localparam int STG_CW = $clog2(STAGE_DEPTH + 1);
   localparam int EXT_W  = ADDR_W + 1;

   // item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_START = 3'd0,
      KIND_BYTE  = 3'd1,
      KIND_STOP  = 3'd2,
      KIND_READ  = 3'd3,
      KIND_WRITE = 3'd4
   } kind_type;

   // what goes into the result register
   typedef enum logic [2:0] {
      OUT_EMPTY_OK = 3'd0,
      OUT_ERR      = 3'd1,
      OUT_WRITE_OK = 3'd2,
      OUT_COMMIT   = 3'd3,
      OUT_READ     = 3'd4
   } out_sel_type;

   typedef struct packed {
      logic        stg_clr;
      logic        stg_push;
      logic        load_stop;
      logic        copy_step;
      logic        rd_start;
      logic        rd_step;
      logic        wr_local;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic stg_few;
      logic sa_bad;
      logic addr_bad;
      logic len_zero;
      logic rem_last;
      logic out_free;
   } status_type;

endpackage

@@ sv/i2ctrf_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module i2ctrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/i2ctrf_ctrl.sv @@
// controller state machine: decodes items and sequences commit and read walks
module i2ctrf_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [i2ctrf_pkg::KIND_W-1:0]   req_kind,
   input  i2ctrf_pkg::status_type          status,
   output i2ctrf_pkg::cmd_type             cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SADDR = 4'b0010,
      ST_COPY  = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = i2ctrf_pkg::OUT_EMPTY_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  i2ctrf_pkg::KIND_START: begin
                     cmd.stg_clr = 1'b1;
                  end
                  i2ctrf_pkg::KIND_BYTE: begin
                     cmd.stg_push = 1'b1;
                  end
                  i2ctrf_pkg::KIND_STOP: begin
                     if (status.stg_few) begin
                        cmd.stg_clr  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = i2ctrf_pkg::OUT_EMPTY_OK;
                     end else begin
                        state_in = ST_SADDR;
                     end
                  end
                  i2ctrf_pkg::KIND_READ: begin
                     if (status.addr_bad) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = i2ctrf_pkg::OUT_ERR;
                     end else if (status.len_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = i2ctrf_pkg::OUT_EMPTY_OK;
                     end else begin
                        cmd.rd_start = 1'b1;
                        state_in     = ST_READ;
                     end
                  end
                  i2ctrf_pkg::KIND_WRITE: begin
                     cmd.out_load = 1'b1;
                     if (status.addr_bad) begin
                        cmd.out_sel = i2ctrf_pkg::OUT_ERR;
                     end else begin
                        cmd.wr_local = 1'b1;
                        cmd.out_sel  = i2ctrf_pkg::OUT_WRITE_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SADDR: begin
            // staged start address is on the staging read port now
            cmd.stg_clr = 1'b1;
            if (status.sa_bad) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = i2ctrf_pkg::OUT_ERR;
               state_in     = ST_IDLE;
            end else begin
               cmd.load_stop = 1'b1;
               state_in      = ST_COPY;
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.rem_last) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = i2ctrf_pkg::OUT_COMMIT;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            if (status.out_free) begin
               cmd.rd_step  = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_sel  = i2ctrf_pkg::OUT_READ;
               if (status.rem_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/i2ctrf_datapath.sv @@
// datapath: staging buffer, register store, walk counters and result register
module i2ctrf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [i2ctrf_pkg::ADDR_W-1:0]   req_address,
   input  logic [i2ctrf_pkg::DATA_W-1:0]   req_byte_in,
   input  logic [i2ctrf_pkg::LEN_W-1:0]    req_read_len,
   input  i2ctrf_pkg::cmd_type             cmd,
   output i2ctrf_pkg::status_type          status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [i2ctrf_pkg::DATA_W-1:0]   rsp_read_byte,
   output logic                            rsp_status,
   output logic [i2ctrf_pkg::LEN_W-1:0]    rsp_count,
   output logic                            rsp_last
);

   localparam logic [i2ctrf_pkg::EXT_W-1:0] REG_LIM =
      i2ctrf_pkg::EXT_W'(i2ctrf_pkg::REG_ENTRIES);
   localparam logic [i2ctrf_pkg::STG_CW-1:0] STG_FULL =
      i2ctrf_pkg::STG_CW'(i2ctrf_pkg::STAGE_DEPTH);

   // staging side
   logic [i2ctrf_pkg::STG_CW-1:0] stg_cnt_ff, stg_cnt_in;
   logic [i2ctrf_pkg::STG_AW-1:0] src_ptr_ff, src_ptr_in;
   logic                          stg_we;
   logic [i2ctrf_pkg::DATA_W-1:0] stg_rd_data;

   // register store side
   logic [i2ctrf_pkg::REG_AW-1:0]      dst_ptr_ff, dst_ptr_in;
   logic [i2ctrf_pkg::REG_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [i2ctrf_pkg::REG_ENTRIES-1:0] reg_vld_ff, reg_vld_in;
   logic                               reg_we;
   logic [i2ctrf_pkg::REG_AW-1:0]      reg_waddr;
   logic [i2ctrf_pkg::DATA_W-1:0]      reg_wdata;
   logic [i2ctrf_pkg::DATA_W-1:0]      reg_rd_data;
   logic [i2ctrf_pkg::DATA_W-1:0]      reg_byte;

   // walk length and reported count
   logic [i2ctrf_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [i2ctrf_pkg::LEN_W-1:0] cnt_ff, cnt_in;

   // length arithmetic
   logic [i2ctrf_pkg::EXT_W-1:0] addr_ext, rd_avail, rd_want, rd_n;
   logic [i2ctrf_pkg::EXT_W-1:0] sa_ext, wr_avail, wr_staged, wr_n;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [i2ctrf_pkg::DATA_W-1:0] read_byte_ff, read_byte_in;
   logic                          status_ff, status_in;
   logic [i2ctrf_pkg::LEN_W-1:0]  count_ff, count_in;
   logic                          last_ff, last_in;
   logic                          out_free;

   i2ctrf_ram #(
      .WIDTH (i2ctrf_pkg::DATA_W),
      .DEPTH (i2ctrf_pkg::STAGE_DEPTH)
   ) u_stage_ram (
      .clock   (clock),
      .wr_en   (stg_we),
      .wr_addr (stg_cnt_ff[i2ctrf_pkg::STG_AW-1:0]),
      .wr_data (req_byte_in),
      .rd_addr (src_ptr_in),
      .rd_data (stg_rd_data)
   );

   i2ctrf_ram #(
      .WIDTH (i2ctrf_pkg::DATA_W),
      .DEPTH (i2ctrf_pkg::REG_ENTRIES)
   ) u_reg_ram (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (reg_waddr),
      .wr_data (reg_wdata),
      .rd_addr (rd_ptr_in),
      .rd_data (reg_rd_data)
   );

   // local read length, clipped at the end of the map
   assign addr_ext = {1'b0, req_address};
   assign rd_avail = REG_LIM - addr_ext;
   assign rd_want  = i2ctrf_pkg::EXT_W'(req_read_len);
   assign rd_n     = (rd_want > rd_avail) ? rd_avail : rd_want;

   // bus commit length from staged start address
   assign sa_ext    = {1'b0, stg_rd_data};
   assign wr_avail  = REG_LIM - sa_ext;
   assign wr_staged = i2ctrf_pkg::EXT_W'(stg_cnt_ff) - i2ctrf_pkg::EXT_W'(1);
   assign wr_n      = (wr_staged > wr_avail) ? wr_avail : wr_staged;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.stg_few  = stg_cnt_ff < i2ctrf_pkg::STG_CW'(2);
      status.sa_bad   = sa_ext >= REG_LIM;
      status.addr_bad = addr_ext >= REG_LIM;
      status.len_zero = rd_n == '0;
      status.rem_last = rem_ff == i2ctrf_pkg::LEN_W'(1);
      status.out_free = out_free;
   end

   assign stg_we = cmd.stg_push && (stg_cnt_ff < STG_FULL);

   always_comb begin
      stg_cnt_in = stg_cnt_ff;
      if (cmd.stg_clr) begin
         stg_cnt_in = '0;
      end else if (stg_we) begin
         stg_cnt_in = stg_cnt_ff + i2ctrf_pkg::STG_CW'(1);
      end
   end

   // staging read data always shows the entry at src_ptr_ff
   always_comb begin
      src_ptr_in = src_ptr_ff;
      if (cmd.load_stop) begin
         src_ptr_in = i2ctrf_pkg::STG_AW'(1);
      end else if (cmd.copy_step) begin
         src_ptr_in = status.rem_last ? '0 : src_ptr_ff + i2ctrf_pkg::STG_AW'(1);
      end
   end

   always_comb begin
      dst_ptr_in = dst_ptr_ff;
      if (cmd.load_stop) begin
         dst_ptr_in = stg_rd_data[i2ctrf_pkg::REG_AW-1:0];
      end else if (cmd.copy_step) begin
         dst_ptr_in = dst_ptr_ff + i2ctrf_pkg::REG_AW'(1);
      end
   end

   // register read data always shows the entry at rd_ptr_ff
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (cmd.rd_start) begin
         rd_ptr_in = req_address[i2ctrf_pkg::REG_AW-1:0];
      end else if (cmd.rd_step && !status.rem_last) begin
         rd_ptr_in = rd_ptr_ff + i2ctrf_pkg::REG_AW'(1);
      end
   end

   always_comb begin
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.load_stop) begin
         rem_in = wr_n[i2ctrf_pkg::LEN_W-1:0];
         cnt_in = wr_n[i2ctrf_pkg::LEN_W-1:0];
      end else if (cmd.rd_start) begin
         rem_in = rd_n[i2ctrf_pkg::LEN_W-1:0];
         cnt_in = rd_n[i2ctrf_pkg::LEN_W-1:0];
      end else if (cmd.copy_step || cmd.rd_step) begin
         rem_in = rem_ff - i2ctrf_pkg::LEN_W'(1);
      end
   end

   // register store write port, shared by commit walk and local write
   assign reg_we    = cmd.copy_step || cmd.wr_local;
   assign reg_waddr = cmd.copy_step ? dst_ptr_ff : req_address[i2ctrf_pkg::REG_AW-1:0];
   assign reg_wdata = cmd.copy_step ? stg_rd_data : req_byte_in;

   always_comb begin
      reg_vld_in = reg_vld_ff;
      if (reg_we) begin
         reg_vld_in[reg_waddr] = 1'b1;
      end
   end

   // entries not written since reset read as zero
   assign reg_byte = reg_vld_ff[rd_ptr_ff] ? reg_rd_data : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      read_byte_in = read_byte_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         read_byte_in = '0;
         status_in    = 1'b0;
         count_in     = '0;
         last_in      = 1'b1;
         case (cmd.out_sel)
            i2ctrf_pkg::OUT_ERR: begin
               status_in = 1'b1;
            end
            i2ctrf_pkg::OUT_WRITE_OK: begin
               count_in = i2ctrf_pkg::LEN_W'(1);
            end
            i2ctrf_pkg::OUT_COMMIT: begin
               count_in = cnt_ff;
            end
            i2ctrf_pkg::OUT_READ: begin
               read_byte_in = reg_byte;
               count_in     = cnt_ff;
               last_in      = status.rem_last;
            end
            default: begin
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_cnt_ff   <= '0;
         src_ptr_ff   <= '0;
         reg_vld_ff   <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_cnt_ff   <= stg_cnt_in;
         src_ptr_ff   <= src_ptr_in;
         reg_vld_ff   <= reg_vld_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ptr_ff   <= dst_ptr_in;
      rd_ptr_ff    <= rd_ptr_in;
      cnt_ff       <= cnt_in;
      read_byte_ff <= read_byte_in;
      status_ff    <= status_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = read_byte_ff;
   assign rsp_status    = status_ff;
   assign rsp_count     = count_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register loaded while a result is pending");

   a_copy_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_step |-> !rsp_valid_ff)
      else $error("commit walk running with a result pending");

   a_walk_rewinds: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_step && status.rem_last |=> src_ptr_ff == '0)
      else $error("staging pointer not rewound after commit");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.stg_push && !cmd.stg_clr && stg_cnt_ff == STG_FULL |=> stg_cnt_ff == STG_FULL)
      else $error("byte taken into a full staging buffer");
`endif

endmodule

@@ sv/i2c_target_register_file.sv @@
// top level of the i2c target register file: controller plus datapath
// start, byte and unused kinds finish in the accept cycle with no result;
//   a local write, short stop or refused/empty read shows its result in the cycle after accept
// stop commit: ST_SADDR, then n bytes copied one per cycle through the store write port;
//   a local read registers its pointer, then gives one byte per cycle unless rsp_ready holds it
// one item at a time; the next item is taken once the last result leaves
// reset: synchronous, clears the state machine, staged count and store valid flags (store reads 0)
module i2c_target_register_file (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [i2ctrf_pkg::KIND_W-1:0]   req_kind,
   input  logic [i2ctrf_pkg::ADDR_W-1:0]   req_address,
   input  logic [i2ctrf_pkg::DATA_W-1:0]   req_byte_in,
   input  logic [i2ctrf_pkg::LEN_W-1:0]    req_read_len,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [i2ctrf_pkg::DATA_W-1:0]   rsp_read_byte,
   output logic                            rsp_status,
   output logic [i2ctrf_pkg::LEN_W-1:0]    rsp_count,
   output logic                            rsp_last
);

   // command and status between the two halves
   i2ctrf_pkg::cmd_type    cmd;
   i2ctrf_pkg::status_type status;

   // state machine: decodes the item kind, walks stop commits and local reads
   i2ctrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, length clipping and the result register
   i2ctrf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_address   (req_address),
      .req_byte_in   (req_byte_in),
      .req_read_len  (req_read_len),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last)
   );

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the i2c target register file
module testbench;

   // package sizes used throughout the bench
   localparam int KIND_W      = i2ctrf_pkg::KIND_W;
   localparam int ADDR_W      = i2ctrf_pkg::ADDR_W;
   localparam int DATA_W      = i2ctrf_pkg::DATA_W;
   localparam int LEN_W       = i2ctrf_pkg::LEN_W;
   localparam int REG_ENTRIES = i2ctrf_pkg::REG_ENTRIES;
   localparam int STAGE_DEPTH = i2ctrf_pkg::STAGE_DEPTH;

   // kinds the block has no use for, it drops them without a response
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
   // a stop needs the address byte plus at least one data byte
   localparam int MIN_STOP_BYTES = 2;
   // a local read never returns more than this many bytes
   localparam int MAX_READ = 64;

   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_ITEMS     = 320;
   localparam int TAIL_ITEMS       = 40;      // no idling on either side once this few remain
   localparam int LONG_HOLD_AT     = 80;      // accepted items before the long receiver hold
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 100;     // longer than a full-map commit or read
   localparam int CYCLE_LIMIT      = 1000000;

   // one request as it goes onto the bus; drain marks a pause, not an item
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] byte_in;
      logic [LEN_W-1:0]  read_len;
      bit                drain;
   } req_item_type;

   // one response, laid out so a whole-struct compare covers every field
   typedef struct packed {
      logic [DATA_W-1:0] read_byte;
      logic              status;
      logic [LEN_W-1:0]  count;
      logic              last;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind     = '0;
   logic [ADDR_W-1:0]   req_address  = '0;
   logic [DATA_W-1:0]   req_byte_in  = '0;
   logic [LEN_W-1:0]    req_read_len = '0;

   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [DATA_W-1:0]   rsp_read_byte;
   logic                rsp_status;
   logic [LEN_W-1:0]    rsp_count;
   logic                rsp_last;

   // stimulus waiting to go out, and responses the block still owes
   req_item_type item_backlog[$];
   rsp_item_type owed_responses[$];

   // shadow copy of the register map and bus staging buffer
   logic [DATA_W-1:0] shadow_regs [REG_ENTRIES];
   logic [DATA_W-1:0] shadow_stage [STAGE_DEPTH];
   int                shadow_staged;

   bit fill_done      = 1'b0;
   bit req_fired      = 1'b0;   // request accepted at the last rising edge
   int accepted_items = 0;
   int mismatches     = 0;
   int send_gap       = 0;
   int rsp_stall      = 0;
   bit long_hold_due  = 1'b1;
   int cycle_count    = 0;

   i2c_target_register_file i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_address   (req_address),
      .req_byte_in   (req_byte_in),
      .req_read_len  (req_read_len),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // single synchronous reset at the start, released on a falling edge
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
   end

   // last stretch of the run goes at full rate on both sides
   function automatic bit in_tail();
      return fill_done && item_backlog.size() < TAIL_ITEMS;
   endfunction

   // random field values at their own widths
   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'($urandom);
   endfunction

   function automatic logic [DATA_W-1:0] rand_byte();
      return DATA_W'($urandom);
   endfunction

   function automatic logic [LEN_W-1:0] rand_len();
      return LEN_W'($urandom);
   endfunction

   // mostly inside the map, now and then anywhere
   function automatic logic [ADDR_W-1:0] pick_addr(int wide_odds);
      if ($urandom_range(0, wide_odds) != 0) begin
         return ADDR_W'($urandom_range(0, REG_ENTRIES - 1));
      end
      return rand_addr();
   endfunction

   function automatic rsp_item_type make_rsp(logic [DATA_W-1:0] rd, logic st,
                                             logic [LEN_W-1:0] cnt, logic lst);
      rsp_item_type r;
      r.read_byte = rd;
      r.status    = st;
      r.count     = cnt;
      r.last      = lst;
      return r;
   endfunction

   // apply one accepted item to the shadow map and queue what it owes
   task automatic register_map_step(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] address,
                                    logic [DATA_W-1:0] byte_in, logic [LEN_W-1:0] read_len);
      int n;
      int sa;
      int a;
      a = int'(address);
      case (kind)
         i2ctrf_pkg::KIND_START: begin
            shadow_staged = 0;
         end
         i2ctrf_pkg::KIND_BYTE: begin
            // bytes past the staging capacity fall on the floor
            if (shadow_staged < STAGE_DEPTH) begin
               shadow_stage[shadow_staged] = byte_in;
               shadow_staged++;
            end
         end
         i2ctrf_pkg::KIND_STOP: begin
            if (shadow_staged < MIN_STOP_BYTES) begin
               owed_responses.push_back(make_rsp('0, 1'b0, '0, 1'b1));
            end else begin
               sa = int'(shadow_stage[0]);
               if (sa >= REG_ENTRIES) begin
                  owed_responses.push_back(make_rsp('0, 1'b1, '0, 1'b1));
               end else begin
                  // auto-increment commit, clipped at the top of the map
                  n = shadow_staged - 1;
                  if (n > REG_ENTRIES - sa) n = REG_ENTRIES - sa;
                  for (int i = 0; i < n; i++) shadow_regs[sa + i] = shadow_stage[1 + i];
                  owed_responses.push_back(make_rsp('0, 1'b0, LEN_W'(n), 1'b1));
               end
            end
            shadow_staged = 0;
         end
         i2ctrf_pkg::KIND_READ: begin
            if (a >= REG_ENTRIES) begin
               owed_responses.push_back(make_rsp('0, 1'b1, '0, 1'b1));
            end else begin
               n = int'(read_len);
               if (n > REG_ENTRIES - a) n = REG_ENTRIES - a;
               if (n > MAX_READ) n = MAX_READ;
               if (n == 0) begin
                  owed_responses.push_back(make_rsp('0, 1'b0, '0, 1'b1));
               end else begin
                  for (int i = 0; i < n; i++) begin
                     owed_responses.push_back(make_rsp(shadow_regs[a + i], 1'b0,
                                                       LEN_W'(n), i == n - 1));
                  end
               end
            end
         end
         i2ctrf_pkg::KIND_WRITE: begin
            if (a >= REG_ENTRIES) begin
               owed_responses.push_back(make_rsp('0, 1'b1, '0, 1'b1));
            end else begin
               shadow_regs[a] = byte_in;
               owed_responses.push_back(make_rsp('0, 1'b0, LEN_W'(1), 1'b1));
            end
         end
         default: begin
            // spare kinds change nothing
         end
      endcase
   endtask

   task automatic queue_item(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] address,
                             logic [DATA_W-1:0] byte_in, logic [LEN_W-1:0] read_len);
      req_item_type it;
      it.kind     = kind;
      it.address  = address;
      it.byte_in  = byte_in;
      it.read_len = read_len;
      it.drain    = 1'b0;
      item_backlog.push_back(it);
   endtask

   task automatic queue_drain();
      req_item_type it;
      it = '{default: '0};
      it.drain = 1'b1;
      item_backlog.push_back(it);
   endtask

   // request driver: changes on the falling edge, holds until accepted
   always @(negedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // still waiting for the block to take the current item
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (item_backlog.size() == 0) begin
         req_valid <= 1'b0;
      end else if (item_backlog[0].drain) begin
         // sender pause: nothing new until every owed response is back
         req_valid <= 1'b0;
         if (owed_responses.size() == 0) void'(item_backlog.pop_front());
      end else if (!in_tail() && $urandom_range(0, 9) == 0) begin
         send_gap  = int'($urandom_range(1, 12)) - 1;
         req_valid <= 1'b0;
      end else begin
         nxt = item_backlog.pop_front();
         req_valid    <= 1'b1;
         req_kind     <= nxt.kind;
         req_address  <= nxt.address;
         req_byte_in  <= nxt.byte_in;
         req_read_len <= nxt.read_len;
      end
   end

   // response receiver: random stall bursts plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (long_hold_due && accepted_items >= LONG_HOLD_AT) begin
         // long hold while the sender keeps offering, so the input backs up
         long_hold_due = 1'b0;
         rsp_stall     = LONG_HOLD_CYCLES - 1;
         rsp_ready     <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
         rsp_stall = int'($urandom_range(1, 12)) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check responses, then fold in any request taken at this edge
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = make_rsp(rsp_read_byte, rsp_status, rsp_count, rsp_last);
            if (owed_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual byte %h status %0d count %0d last %0d",
                        $time, got.read_byte, got.status, got.count, got.last);
               mismatches++;
            end else begin
               want = owed_responses.pop_front();
               if (got !== want) begin
                  $display("%0t: response mismatch expected byte %h status %0d count %0d last %0d",
                           $time, want.read_byte, want.status, want.count, want.last);
                  $display("%0t:                    actual byte %h status %0d count %0d last %0d",
                           $time, got.read_byte, got.status, got.count, got.last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_fired = 1'b1;
            accepted_items++;
            register_map_step(req_kind, req_address, req_byte_in, req_read_len);
         end
      end
   end

   // watchdog on total run length
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run timed out", $time);
      $display("== FAIL ==");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int counted;
      int n_data;
      bit mid_drain_done;
      logic [KIND_W-1:0] k;

      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      foreach (shadow_stage[i]) shadow_stage[i] = '0;
      shadow_staged = 0;

      // directed: reads of the cleared map, edge addresses, length clipping
      queue_item(i2ctrf_pkg::KIND_READ,  8'd0,   8'h00, LEN_W'(REG_ENTRIES));
      queue_item(i2ctrf_pkg::KIND_WRITE, 8'd31,  8'hff, 7'd0);
      queue_item(i2ctrf_pkg::KIND_WRITE, 8'd32,  8'h00, 7'd0);
      queue_item(i2ctrf_pkg::KIND_WRITE, 8'd255, 8'ha5, 7'd127);
      queue_item(i2ctrf_pkg::KIND_WRITE, 8'd0,   8'h5a, 7'd0);
      queue_item(i2ctrf_pkg::KIND_READ,  8'd31,  8'h00, 7'd64);
      queue_item(i2ctrf_pkg::KIND_READ,  8'd5,   8'h00, 7'd0);
      queue_item(i2ctrf_pkg::KIND_READ,  8'd32,  8'h00, 7'd1);
      queue_item(i2ctrf_pkg::KIND_READ,  8'd255, 8'hff, 7'd127);
      // stop with nothing staged, then with only the address byte
      queue_item(i2ctrf_pkg::KIND_STOP,  8'd0,   8'h00, 7'd0);
      queue_item(i2ctrf_pkg::KIND_START, 8'd0,   8'h00, 7'd0);
      queue_item(i2ctrf_pkg::KIND_BYTE,  8'd0,   8'h03, 7'd0);
      queue_item(i2ctrf_pkg::KIND_STOP,  8'd0,   8'h00, 7'd0);
      // commit that runs off the end of the map
      queue_item(i2ctrf_pkg::KIND_START, 8'd0,   8'h00, 7'd0);
      queue_item(i2ctrf_pkg::KIND_BYTE,  8'd0,   8'd30, 7'd0);
      queue_item(i2ctrf_pkg::KIND_BYTE,  8'd0,   8'haa, 7'd0);
      queue_item(i2ctrf_pkg::KIND_BYTE,  8'd0,   8'h55, 7'd0);
      queue_item(i2ctrf_pkg::KIND_BYTE,  8'd0,   8'h12, 7'd0);
      queue_item(i2ctrf_pkg::KIND_STOP,  8'd0,   8'h00, 7'd0);
      // staged start address outside the map
      queue_item(i2ctrf_pkg::KIND_START, 8'd0,   8'h00, 7'd0);
      queue_item(i2ctrf_pkg::KIND_BYTE,  8'd0,   8'd40, 7'd0);
      queue_item(i2ctrf_pkg::KIND_BYTE,  8'd0,   8'h77, 7'd0);
      queue_item(i2ctrf_pkg::KIND_STOP,  8'd0,   8'h00, 7'd0);
      // spare kinds, then read back the whole map
      queue_item(KIND_SPARE_LO, 8'hff, 8'hff, 7'd127);
      queue_item(KIND_SPARE_HI, 8'd0,  8'h00, 7'd0);
      queue_item(i2ctrf_pkg::KIND_READ,  8'd0,   8'h00, 7'd127);
      queue_drain();

      // random: mostly well-formed bus writes, local accesses, some noise
      counted        = 0;
      mid_drain_done = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // bus transfer, occasionally missing its start or stop
               n_data = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 40))
                                                    : int'($urandom_range(0, 6));
               if ($urandom_range(0, 9) != 0) begin
                  queue_item(i2ctrf_pkg::KIND_START, rand_addr(), rand_byte(), rand_len());
                  counted++;
               end
               queue_item(i2ctrf_pkg::KIND_BYTE, rand_addr(), DATA_W'(pick_addr(6)),
                          rand_len());
               counted++;
               for (int i = 0; i < n_data; i++) begin
                  queue_item(i2ctrf_pkg::KIND_BYTE, rand_addr(), rand_byte(), rand_len());
                  counted++;
               end
               if ($urandom_range(0, 9) != 0) begin
                  queue_item(i2ctrf_pkg::KIND_STOP, rand_addr(), rand_byte(), rand_len());
                  counted++;
               end
            end
            4, 5: begin
               queue_item(i2ctrf_pkg::KIND_WRITE, pick_addr(5), rand_byte(), rand_len());
               counted++;
            end
            6, 7: begin
               // mostly short reads, a few long or out of range ones
               queue_item(i2ctrf_pkg::KIND_READ, pick_addr(9), rand_byte(),
                          ($urandom_range(0, 9) != 0) ? LEN_W'($urandom_range(0, 8))
                                                      : LEN_W'($urandom_range(0, 127)));
               counted++;
            end
            default: begin
               k = KIND_W'($urandom_range(0, int'(KIND_SPARE_HI)));
               queue_item(k, rand_addr(), rand_byte(), rand_len());
               if (k < KIND_SPARE_LO) counted++;
            end
         endcase
         if (!mid_drain_done && counted >= RANDOM_ITEMS / 2) begin
            queue_drain();
            mid_drain_done = 1'b1;
         end
      end
      fill_done = 1'b1;

      // wait for every item to go out and every owed response to come back
      @(negedge reset);
      while (item_backlog.size() != 0 || req_valid || owed_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/i2ctrf_pkg.sv
sv/i2ctrf_ram.sv
sv/i2ctrf_ctrl.sv
sv/i2ctrf_datapath.sv
sv/i2c_target_register_file.sv
dv/testbench.sv
